FILE: hw/rtl/rtea_block_cipher_assert.svh
// Assertion macros shared by the RTEA cipher RTL.
`ifndef RTEA_BLOCK_CIPHER_ASSERT_SVH
`define RTEA_BLOCK_CIPHER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RTEA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/rtea_pkg.sv
// Shared types, constants and the round mixing function of the RTEA cipher.
`default_nettype none

package rtea_pkg;

	localparam int unsigned WORD_W        = 32;
	localparam int unsigned KEY_REG_W     = 64;
	localparam int unsigned KEY_REGS      = 4;
	localparam int unsigned KEY_WORDS     = 8;
	localparam int unsigned ROUNDS_NARROW = 48;
	localparam int unsigned ROUNDS_WIDE   = 64;
	localparam int unsigned NUM_CELLS     = ROUNDS_WIDE;
	localparam int unsigned ROUND_W       = $clog2(ROUNDS_WIDE);
	localparam int unsigned COUNT_W       = ROUND_W + 1;
	localparam int unsigned REG_IDX_W     = 3;
	localparam int unsigned MIX_LEFT      = 6;
	localparam int unsigned MIX_RIGHT     = 8;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_KEY_01 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_23 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY_45 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY_67 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WIDE   = 3'd4;

	// Block operation codes.
	localparam logic KIND_ENCRYPT = 1'b0;
	localparam logic KIND_DECRYPT = 1'b1;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] rtea_keys_t;

	typedef struct packed {
		rtea_keys_t keys;
		logic       wide;
	} rtea_key_cfg_t;

	// One block in flight, handed from cell to cell.
	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} rtea_stage_t;

	function automatic logic [WORD_W-1:0] rtea_mix(input logic [WORD_W-1:0] x);
		return (x << MIX_LEFT) ^ (x >> MIX_RIGHT);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rtea_if.sv
// Valid/ready channel interfaces for blocks in, blocks out and register writes.
`default_nettype none

interface rtea_in_if;
	import rtea_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [WORD_W-1:0] left_in;
	logic [WORD_W-1:0] right_in;
	modport source (output valid, kind, left_in, right_in, input ready);
	modport sink   (input valid, kind, left_in, right_in, output ready);
endinterface

interface rtea_out_if;
	import rtea_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] left_out;
	logic [WORD_W-1:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface rtea_cfg_if;
	import rtea_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [KEY_REG_W-1:0] wr_data;
	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rtea_key_regs.sv
// Key and key-size configuration registers of the RTEA cipher.
`default_nettype none

module rtea_key_regs
	import rtea_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	rtea_cfg_if.sink     cfg,
	output rtea_key_cfg_t key_cfg
);

	logic [KEY_REGS-1:0][KEY_REG_W-1:0] key_q;
	logic                               wide_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			wide_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_KEY_01: key_q[0] <= cfg.wr_data;
				REG_KEY_23: key_q[1] <= cfg.wr_data;
				REG_KEY_45: key_q[2] <= cfg.wr_data;
				REG_KEY_67: key_q[3] <= cfg.wr_data;
				REG_WIDE:   wide_q   <= cfg.wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// Each 64-bit register carries the odd word in its upper half.
	always_comb begin
		for (int j = 0; j < KEY_REGS; j++) begin
			key_cfg.keys[2*j]   = key_q[j][WORD_W-1:0];
			key_cfg.keys[2*j+1] = key_q[j][KEY_REG_W-1:WORD_W];
		end
		key_cfg.wide = wide_q;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rtea_cell.sv
// One round cell of the RTEA pipeline: applies its round, or passes the block on.
`default_nettype none

module rtea_cell
	import rtea_pkg::*;
#(
	parameter int unsigned CellIdx = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire rtea_key_cfg_t key_cfg,
	input  wire rtea_stage_t   word_in,
	output rtea_stage_t        word_out
);

	localparam logic [COUNT_W-1:0] CELL_POS = COUNT_W'(CellIdx);

	logic [COUNT_W-1:0]  rounds;
	logic [COUNT_W-1:0]  rev_pos;
	logic [ROUND_W-1:0]  round_idx;
	logic                active;
	logic [2:0]          key_sel;
	logic [WORD_W-1:0]   src;
	logic [WORD_W-1:0]   dst;
	logic [WORD_W-1:0]   f_val;
	logic [WORD_W-1:0]   new_val;
	logic [WORD_W-1:0]   next_left;
	logic [WORD_W-1:0]   next_right;
	logic                valid_q;
	logic                kind_q;
	logic [WORD_W-1:0]   left_q;
	logic [WORD_W-1:0]   right_q;

	// Encryption runs round k in cell k; decryption runs the rounds backwards.
	// Cells beyond the round count only delay the block.
	always_comb begin
		rounds     = key_cfg.wide ? COUNT_W'(ROUNDS_WIDE) : COUNT_W'(ROUNDS_NARROW);
		active     = CELL_POS < rounds;
		rev_pos    = rounds - COUNT_W'(1) - CELL_POS;
		round_idx  = (word_in.kind == KIND_DECRYPT) ? rev_pos[ROUND_W-1:0]
		                                            : CELL_POS[ROUND_W-1:0];
		key_sel    = {round_idx[2] & key_cfg.wide, round_idx[1:0]};
		// Odd rounds update the right word from the left one.
		src        = round_idx[0] ? word_in.left  : word_in.right;
		dst        = round_idx[0] ? word_in.right : word_in.left;
		f_val      = src + rtea_mix(src) + key_cfg.keys[key_sel] + WORD_W'(round_idx);
		new_val    = (word_in.kind == KIND_DECRYPT) ? dst - f_val : dst + f_val;
		next_left  = word_in.left;
		next_right = word_in.right;
		if (active) begin
			if (round_idx[0]) begin
				next_right = new_val;
			end else begin
				next_left = new_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q  <= word_in.kind;
			left_q  <= next_left;
			right_q <= next_right;
		end
	end

	assign word_out = {valid_q, kind_q, left_q, right_q};

endmodule

`default_nettype wire

FILE: hw/rtl/rtea_block_cipher.sv
// Top level of the RTEA block cipher: key registers and a chain of round cells.
//
//   channel  | dir | payload                     | accepted when
//   ---------+-----+-----------------------------+----------------------
//   blk_in   | in  | kind, left_in, right_in     | valid && ready
//   blk_out  | out | left_out, right_out         | valid && ready
//   cfg      | in  | reg_index, wr_data          | valid && ready
//
// Every word passes through every cell of the chain, for
// both key sizes; with a 128-bit key the last 16 cells only carry the block.
// A new word is taken in every cycle in which the chain advances, so the sustained rate is one block per cycle.
// The chain moves as a whole: it stalls only while the last cell holds a result
// that the sink does not take, and blk_in.ready is low in exactly those cycles.
// Reset clears the key registers, the key-size flag and all cell valid bits.
// Register writes are taken in any cycle, but every cell reads the live key, so
// the key may only change while no block is in the chain.
`default_nettype none

module rtea_block_cipher
	import rtea_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	rtea_in_if.sink   blk_in,
	rtea_out_if.source blk_out,
	rtea_cfg_if.sink  cfg
);

`include "rtea_block_cipher_assert.svh"

	rtea_key_cfg_t              key_cfg;
	rtea_stage_t [NUM_CELLS:0]  stage;
	logic [NUM_CELLS-1:0]       cell_valid;
	logic                       advance;
	logic                       in_fire;
	logic                       cfg_fire;
	logic                       wide_fire;

	rtea_key_regs u_key_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.key_cfg (key_cfg)
	);

	// The whole chain shifts unless the result in the last cell is held up.
	assign advance      = !stage[NUM_CELLS].valid || blk_out.ready;
	assign blk_in.ready = advance;

	assign stage[0] = {blk_in.valid, blk_in.kind, blk_in.left_in, blk_in.right_in};

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		rtea_cell #(
			.CellIdx (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.key_cfg  (key_cfg),
			.word_in  (stage[k]),
			.word_out (stage[k+1])
		);
		assign cell_valid[k] = stage[k+1].valid;
	end

	// The last cell doubles as the output register.
	assign blk_out.valid     = stage[NUM_CELLS].valid;
	assign blk_out.left_out  = stage[NUM_CELLS].left;
	assign blk_out.right_out = stage[NUM_CELLS].right;

	assign in_fire   = blk_in.valid && blk_in.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign wide_fire = cfg_fire && (cfg.reg_index == REG_WIDE);

	// An accepted word must land in the first cell.
	`RTEA_ASSERT_NEXT(a_accept_lands, in_fire, cell_valid[0], "accepted word lost at first cell")

	// A stalled chain keeps every word where it is.
	`RTEA_ASSERT_NEXT(a_stall_holds, !advance, $stable(cell_valid), "chain moved during a stall")

	// A write to the key-size register takes effect in the next cycle.
	`RTEA_ASSERT_NEXT(a_wide_write, wide_fire, key_cfg.wide == $past(cfg.wr_data[0]), "flag write lost")

	// Without a write, the key-size flag never changes.
	`RTEA_ASSERT_NEXT(a_wide_steady, !cfg_fire, $stable(key_cfg.wide), "key-size flag changed")

endmodule

`default_nettype wire

FILE: bench/rtea_block_cipher_checker.sv
// Checker that predicts and compares every processed block of the RTEA cipher.
`timescale 1ns / 1ps

module rtea_block_cipher_checker
	import rtea_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rtea_in_if          blk_in,
	rtea_out_if         blk_out,
	rtea_cfg_if         cfg,
	output int unsigned errors,
	output int unsigned pending,
	output int unsigned blocks_checked
);

	typedef struct packed {
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} block_t;

	block_t               expected_blocks[$];
	logic [KEY_REG_W-1:0] key_pairs[KEY_REGS];
	logic                 wide_sel;

	initial begin
		errors = 0;
		pending = 0;
		blocks_checked = 0;
		wide_sel = 1'b0;
		foreach (key_pairs[k]) key_pairs[k] = '0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns checker: %s", $time, what);
	endtask

	function automatic logic [WORD_W-1:0] scramble(input logic [WORD_W-1:0] x);
		return (x << MIX_LEFT) ^ (x >> MIX_RIGHT);
	endfunction

	// With the narrow key, words 4 to 7 fold back onto words 0 to 3.
	function automatic logic [WORD_W-1:0] round_key(input int unsigned round_no);
		int unsigned          w;
		logic [KEY_REG_W-1:0] pair;
		w = round_no % KEY_WORDS;
		if (!wide_sel) w = w % (KEY_WORDS / 2);
		pair = key_pairs[w / 2];
		return (w % 2 == 1) ? pair[KEY_REG_W-1:WORD_W] : pair[WORD_W-1:0];
	endfunction

	function automatic block_t cipher_block(input logic kind, input block_t blk);
		block_t      b;
		int unsigned rounds;
		int unsigned i;
		b = blk;
		rounds = wide_sel ? ROUNDS_WIDE : ROUNDS_NARROW;
		if (kind == KIND_ENCRYPT) begin
			for (i = 0; i < rounds; i += 2) begin
				b.left += b.right + scramble(b.right) + round_key(i) + i;
				b.right += b.left + scramble(b.left) + round_key(i + 1) + (i + 1);
			end
		end else begin
			for (i = rounds; i > 0; i -= 2) begin
				b.right -= b.left + scramble(b.left) + round_key(i - 1) + (i - 1);
				b.left -= b.right + scramble(b.right) + round_key(i - 2) + (i - 2);
			end
		end
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		block_t got;
		block_t want;
		if (!arst_n) begin
			foreach (key_pairs[k]) key_pairs[k] = '0;
			wide_sel = 1'b0;
		end else begin
			// Prediction uses the key as it stood before this edge.
			if (blk_in.valid && blk_in.ready)
				expected_blocks.push_back(cipher_block(blk_in.kind,
					{blk_in.left_in, blk_in.right_in}));

			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index) inside
					REG_KEY_01, REG_KEY_23, REG_KEY_45, REG_KEY_67:
						key_pairs[cfg.reg_index] = cfg.wr_data;
					REG_WIDE:
						wide_sel = cfg.wr_data[0];
					default: ;
				endcase
			end

			if (blk_out.valid && blk_out.ready) begin
				got = {blk_out.left_out, blk_out.right_out};
				if (expected_blocks.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h %h", got.left, got.right));
				end else begin
					want = expected_blocks.pop_front();
					blocks_checked++;
					if (got.left !== want.left)
						report_mismatch($sformatf("left_out %h, expected %h",
							got.left, want.left));
					if (got.right !== want.right)
						report_mismatch($sformatf("right_out %h, expected %h",
							got.right, want.right));
				end
			end
			pending = expected_blocks.size();
		end
	end

endmodule

FILE: bench/tb_rtea_block_cipher.sv
// Top of the RTEA cipher testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb_rtea_block_cipher
	import rtea_pkg::*;
();

	// Register indexes past the wide-key flag decode to nothing.
	localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned TAIL_CYCLES   = 80;
	localparam int unsigned SETTINGS_EACH = 5;
	localparam int unsigned BLOCKS_EACH   = 90;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned cycles = 0;

	// Percentages of cycles in which each side sits idle.
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;

	// Long receiver hold-off, loaded by the stimulus and counted down on its own.
	logic        hold_load;
	int unsigned hold_left = 0;

	int unsigned check_errors;
	int unsigned check_pending;
	int unsigned check_count;

	int unsigned blocks_sent = 0;
	int unsigned decrypts_sent = 0;
	int unsigned key_settings = 0;
	int unsigned wide_settings = 0;

	rtea_in_if  blk_in();
	rtea_out_if blk_out();
	rtea_cfg_if cfg();

	rtea_block_cipher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.blk_in (blk_in),
		.blk_out(blk_out),
		.cfg    (cfg)
	);

	rtea_block_cipher_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.blk_in        (blk_in),
		.blk_out       (blk_out),
		.cfg           (cfg),
		.errors        (check_errors),
		.pending       (check_pending),
		.blocks_checked(check_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The watchdog: a correct run finishes far below this many cycles.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_load)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// The receiver takes a word whenever it is not holding off and the coin allows.
	always @(negedge clk) begin
		if (hold_left != 0)
			blk_out.ready <= 1'b0;
		else
			blk_out.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Offers one block, after a random number of idle cycles, and returns at the
	// falling edge after it was taken. Valid stays high so back-to-back words
	// need no extra assignment; the caller lowers it at the end of a burst.
	task automatic send_block(input logic kind, input logic [WORD_W-1:0] left,
		input logic [WORD_W-1:0] right);
		while ($urandom_range(99) < tx_idle_pct) begin
			blk_in.valid <= 1'b0;
			@(negedge clk);
		end
		blk_in.valid    <= 1'b1;
		blk_in.kind     <= kind;
		blk_in.left_in  <= left;
		blk_in.right_in <= right;
		@(posedge clk);
		while (!blk_in.ready) @(posedge clk);
		@(negedge clk);
		blocks_sent++;
		if (kind == KIND_DECRYPT) decrypts_sent++;
	endtask

	// Data words lean toward the extremes now and then.
	function automatic logic [WORD_W-1:0] random_data();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_REG_W-1:0] random_key_pair();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_random_block();
		send_block($urandom_range(1) ? KIND_DECRYPT : KIND_ENCRYPT,
			random_data(), random_data());
	endtask

	// Ends a burst: valid goes low and every expected result must come back
	// before the key registers may be touched again.
	task automatic wait_for_results();
		blk_in.valid <= 1'b0;
		do @(negedge clk); while (check_pending != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
		input logic [KEY_REG_W-1:0] data);
		cfg.valid     <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wr_data   <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_keys(input logic [KEY_REG_W-1:0] k01, input logic [KEY_REG_W-1:0] k23,
		input logic [KEY_REG_W-1:0] k45, input logic [KEY_REG_W-1:0] k67, input logic wide);
		write_reg(REG_KEY_01, k01);
		write_reg(REG_KEY_23, k23);
		write_reg(REG_KEY_45, k45);
		write_reg(REG_KEY_67, k67);
		write_reg(REG_WIDE, {{(KEY_REG_W-1){1'b0}}, wide});
		cfg.valid <= 1'b0;
		key_settings++;
		if (wide) wide_settings++;
	endtask

	// One idling pattern over several random keys. With a hold-off the receiver
	// stops for a long stretch while the sender keeps offering, so the round
	// chain fills up and has to push back on its input.
	task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
		input bit with_hold);
		int unsigned s;
		int unsigned n;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (s = 0; s < SETTINGS_EACH; s++) begin
			load_keys(random_key_pair(), random_key_pair(), random_key_pair(),
				random_key_pair(), 1'($urandom_range(1)));
			if (with_hold && s == 0) begin
				hold_load <= 1'b1;
				@(negedge clk);
				hold_load <= 1'b0;
			end
			for (n = 0; n < BLOCKS_EACH; n++) send_random_block();
			wait_for_results();
		end
	endtask

	initial begin
		int idx;
		arst_n          = 1'b0;
		hold_load       = 1'b0;
		tx_idle_pct     = 0;
		rx_idle_pct     = 30;
		blk_in.valid    = 1'b0;
		blk_in.kind     = KIND_ENCRYPT;
		blk_in.left_in  = '0;
		blk_in.right_in = '0;
		blk_out.ready   = 1'b0;
		cfg.valid       = 1'b0;
		cfg.reg_index   = REG_KEY_01;
		cfg.wr_data     = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The all-zero narrow key left by reset, on the extreme blocks.
		send_block(KIND_ENCRYPT, '0, '0);
		send_block(KIND_ENCRYPT, '1, '1);
		send_block(KIND_DECRYPT, '0, '0);
		send_block(KIND_DECRYPT, '1, '1);
		wait_for_results();

		// All-ones wide key, 64 rounds.
		load_keys('1, '1, '1, '1, 1'b1);
		send_block(KIND_ENCRYPT, '0, '0);
		send_block(KIND_ENCRYPT, '1, '1);
		send_block(KIND_DECRYPT, '0, '0);
		send_block(KIND_DECRYPT, '1, '1);
		send_block(KIND_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
		wait_for_results();

		// Narrow key with distinct upper words: those words must be ignored and
		// the lower four reused for rounds that name words 4 to 7.
		load_keys({$urandom, $urandom}, {$urandom, $urandom}, '1, '1, 1'b0);
		send_block(KIND_ENCRYPT, $urandom, $urandom);
		send_block(KIND_DECRYPT, $urandom, $urandom);
		send_block(KIND_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
		wait_for_results();

		// Only bit 0 of the flag counts: all upper bits set still means narrow.
		write_reg(REG_WIDE, 64'hFFFF_FFFF_FFFF_FFFE);
		// Writes past the last register must change nothing.
		for (idx = int'(REG_SPARE_FIRST); idx <= int'(REG_SPARE_LAST); idx++)
			write_reg(idx[REG_IDX_W-1:0], '1);
		cfg.valid <= 1'b0;
		send_block(KIND_ENCRYPT, $urandom, $urandom);
		send_block(KIND_DECRYPT, $urandom, $urandom);
		wait_for_results();

		// And a set bit 0 under a noisy upper half selects the wide key.
		write_reg(REG_WIDE, 64'h8000_0000_7FFF_FFFF);
		cfg.valid <= 1'b0;
		send_block(KIND_ENCRYPT, $urandom, $urandom);
		send_block(KIND_DECRYPT, $urandom, $urandom);
		wait_for_results();

		// Random part: slow receiver, then slow sender, then full rate with a
		// long receiver hold-off to back the chain up.
		run_phase(16, 82, 1'b0);
		run_phase(82, 16, 1'b0);
		run_phase(0, 0, 1'b1);

		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d blocks (%0d decrypted) under %0d key settings, %0d of them wide.",
			blocks_sent, decrypts_sent, key_settings, wide_settings);
		$display("Checked %0d results against the predicted blocks.", check_count);
		if (check_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
